### sv/ialu_pkg.sv
package ialu_pkg;

  localparam int unsigned XLEN = 64;
  localparam int unsigned DIV_STAGES = XLEN;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_MUL  = 5'd2,
    OP_DIV  = 5'd3,
    OP_MOD  = 5'd4,
    OP_OR   = 5'd5,
    OP_XOR  = 5'd6,
    OP_AND  = 5'd7,
    OP_SHL  = 5'd8,
    OP_SHR  = 5'd9,
    OP_EQ   = 5'd10,
    OP_NE   = 5'd11,
    OP_LT   = 5'd12,
    OP_LE   = 5'd13,
    OP_GT   = 5'd14,
    OP_GE   = 5'd15,
    OP_LAND = 5'd16,
    OP_LOR  = 5'd17,
    OP_NEG  = 5'd18,
    OP_LNOT = 5'd19,
    OP_NOT  = 5'd20
  } mode_e;

  // One item as it travels through the divider stages. For operations other
  // than divide and modulo, quot already holds the finished result.
  typedef struct packed {
    logic            valid;
    mode_e           op;
    logic            neg_q;
    logic            neg_r;
    logic            zero_b;
    logic [XLEN-1:0] divisor;
    logic [XLEN-1:0] rem;
    logic [XLEN-1:0] quot;
  } div_t;

endpackage

### sv/ialu_div_stage.sv
module ialu_div_stage
  import ialu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  div_t d_i,
  output div_t q_o
);

  logic [XLEN:0]   shifted;
  logic [XLEN:0]   diff;
  logic            is_div;
  div_t            q_d;
  div_t            q_q;

  // One restoring step: bring in the next dividend bit and try to subtract.
  always_comb begin
    is_div  = (d_i.op == OP_DIV) || (d_i.op == OP_MOD);
    shifted = {d_i.rem, d_i.quot[XLEN-1]};
    diff    = shifted - {1'b0, d_i.divisor};
    q_d     = d_i;
    if (is_div) begin
      if (!diff[XLEN]) begin
        q_d.rem = diff[XLEN-1:0];
      end else begin
        q_d.rem = shifted[XLEN-1:0];
      end
      q_d.quot = {d_i.quot[XLEN-2:0], ~diff[XLEN]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

### sv/integer_alu_64_top.sv
// Channel  Direction  tdata                           tuser
// s_axis   in         [63:0] operand_a, [127:64] b    [4:0] mode
// m_axis   out        [63:0] result                   -
//
// Items pass the stages ahead of the divider, the divider and the output
// register; one item can be taken per cycle unless the output stalls. The
// divider retires one quotient bit in each of 64 stages; every operation
// follows one path. Reset clears all valid bits. A stall at the output holds
// the whole pipeline, so s_axis_tready falls only while the result waits.
module integer_alu_64_top
  import ialu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [2*XLEN-1:0]   s_axis_tdata,  // operand_a, operand_b
  input  logic [4:0]          s_axis_tuser,  // mode
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [XLEN-1:0]     m_axis_tdata   // result
);

  logic            adv;

  logic            v1_q;
  mode_e           op1_q;
  logic [XLEN-1:0] a1_q, b1_q;

  logic            v2_q;
  mode_e           op2_q;
  logic [XLEN-1:0] fast2_d, fast2_q;
  logic [XLEN-1:0] pll2_q, ma2_d, ma2_q, mb2_d, mb2_q;
  logic [31:0]     plh2_q, phl2_q;
  logic            nq2_q, nr2_q, zb2_q;

  div_t            st [0:DIV_STAGES];
  div_t            st0_d, st0_q;

  logic            out_v_q;
  logic [XLEN-1:0] out_d, out_q;

  logic [5:0]      sh;
  logic            lt_ab, lt_ba;

  assign adv           = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v1_q    <= s_axis_tvalid;
      v2_q    <= v1_q;
      out_v_q <= st[DIV_STAGES].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q <= mode_e'(s_axis_tuser);
      a1_q  <= s_axis_tdata[XLEN-1:0];
      b1_q  <= s_axis_tdata[2*XLEN-1:XLEN];
    end
  end

  // Second stage: the operations other than multiply, divide and modulo,
  // operand magnitudes and 32-bit partial products of the multiplication.
  always_comb begin
    sh    = b1_q[5:0];
    lt_ab = $signed(a1_q) < $signed(b1_q);
    lt_ba = $signed(b1_q) < $signed(a1_q);
    ma2_d = a1_q[XLEN-1] ? (~a1_q + 1'b1) : a1_q;
    mb2_d = b1_q[XLEN-1] ? (~b1_q + 1'b1) : b1_q;
    case (op1_q)
      OP_ADD:  fast2_d = a1_q + b1_q;
      OP_SUB:  fast2_d = a1_q - b1_q;
      OP_OR:   fast2_d = a1_q | b1_q;
      OP_XOR:  fast2_d = a1_q ^ b1_q;
      OP_AND:  fast2_d = a1_q & b1_q;
      OP_SHL:  fast2_d = a1_q << sh;
      OP_SHR:  fast2_d = $unsigned($signed(a1_q) >>> sh);
      OP_EQ:   fast2_d = {{(XLEN-1){1'b0}}, a1_q == b1_q};
      OP_NE:   fast2_d = {{(XLEN-1){1'b0}}, a1_q != b1_q};
      OP_LT:   fast2_d = {{(XLEN-1){1'b0}}, lt_ab};
      OP_LE:   fast2_d = {{(XLEN-1){1'b0}}, !lt_ba};
      OP_GT:   fast2_d = {{(XLEN-1){1'b0}}, lt_ba};
      OP_GE:   fast2_d = {{(XLEN-1){1'b0}}, !lt_ab};
      OP_LAND: fast2_d = {{(XLEN-1){1'b0}}, (a1_q != '0) && (b1_q != '0)};
      OP_LOR:  fast2_d = {{(XLEN-1){1'b0}}, (a1_q != '0) || (b1_q != '0)};
      OP_NEG:  fast2_d = ~a1_q + 1'b1;
      OP_LNOT: fast2_d = {{(XLEN-1){1'b0}}, a1_q == '0};
      OP_NOT:  fast2_d = ~a1_q;
      default: fast2_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op2_q   <= op1_q;
      fast2_q <= fast2_d;
      pll2_q  <= a1_q[31:0] * b1_q[31:0];
      plh2_q  <= 32'(a1_q[31:0] * b1_q[63:32]);
      phl2_q  <= 32'(a1_q[63:32] * b1_q[31:0]);
      ma2_q   <= ma2_d;
      mb2_q   <= mb2_d;
      nq2_q   <= a1_q[XLEN-1] ^ b1_q[XLEN-1];
      nr2_q   <= a1_q[XLEN-1];
      zb2_q   <= (b1_q == '0);
    end
  end

  // Third stage: finish the product and load the divider.
  always_comb begin
    st0_d.valid   = v2_q;
    st0_d.op      = op2_q;
    st0_d.neg_q   = nq2_q;
    st0_d.neg_r   = nr2_q;
    st0_d.zero_b  = zb2_q;
    st0_d.divisor = mb2_q;
    st0_d.rem     = '0;
    case (op2_q)
      OP_MUL:         st0_d.quot = pll2_q + {plh2_q + phl2_q, 32'd0};
      OP_DIV, OP_MOD: st0_d.quot = ma2_q;
      default:        st0_d.quot = fast2_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st0_q <= '0;
    end else if (adv) begin
      st0_q <= st0_d;
    end
  end

  assign st[0] = st0_q;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    ialu_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .d_i    (st[i]),
      .q_o    (st[i+1])
    );
  end

  // Signs and the zero-divisor case are applied at the end.
  always_comb begin
    case (st[DIV_STAGES].op)
      OP_DIV: begin
        if (st[DIV_STAGES].zero_b) begin
          out_d = '0;
        end else if (st[DIV_STAGES].neg_q) begin
          out_d = ~st[DIV_STAGES].quot + 1'b1;
        end else begin
          out_d = st[DIV_STAGES].quot;
        end
      end
      OP_MOD: begin
        if (st[DIV_STAGES].zero_b) begin
          out_d = '0;
        end else if (st[DIV_STAGES].neg_r) begin
          out_d = ~st[DIV_STAGES].rem + 1'b1;
        end else begin
          out_d = st[DIV_STAGES].rem;
        end
      end
      default: out_d = st[DIV_STAGES].quot;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import ialu_pkg::*;

  localparam int unsigned LATENCY = 68;
  localparam logic [63:0] MIN_VAL = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_VAL = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ALL_ONE = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [4:0]  UNUSED_OP = 5'd31;

  typedef struct {
    logic [4:0]  mode;
    logic [63:0] a;
    logic [63:0] b;
    logic        known;
    logic [63:0] res;
  } row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [127:0]      s_axis_tdata = '0;
  logic [4:0]        s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [63:0]       m_axis_tdata;

  logic [63:0] results_due[$];
  int unsigned mismatches = 0;
  bit          stim_done = 1'b0;
  bit          long_hold = 1'b0;

  integer_alu_64_top dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic logic [63:0] alu_result(logic [4:0] mode, logic [63:0] a,
                                             logic [63:0] b);
    logic signed [63:0] sa, sb;
    logic [63:0] ma, mb, q, r;
    sa = a;
    sb = b;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    case (mode)
      OP_ADD:  return a + b;
      OP_SUB:  return a - b;
      OP_MUL:  return a * b;
      OP_DIV, OP_MOD: begin
        if (b == 0) return '0;
        q = ma / mb;
        r = ma % mb;
        if (mode == OP_DIV) return (a[63] ^ b[63]) ? -q : q;
        return a[63] ? -r : r;
      end
      OP_OR:   return a | b;
      OP_XOR:  return a ^ b;
      OP_AND:  return a & b;
      OP_SHL:  return a << b[5:0];
      OP_SHR:  return sa >>> b[5:0];
      OP_EQ:   return 64'(a == b);
      OP_NE:   return 64'(a != b);
      OP_LT:   return 64'(sa < sb);
      OP_LE:   return 64'(sa <= sb);
      OP_GT:   return 64'(sa > sb);
      OP_GE:   return 64'(sa >= sb);
      OP_LAND: return 64'(a != 0 && b != 0);
      OP_LOR:  return 64'(a != 0 || b != 0);
      OP_NEG:  return -a;
      OP_LNOT: return 64'(a == 0);
      OP_NOT:  return ~a;
      default: return '0;
    endcase
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = MIN_VAL;
      1: v = MAX_VAL;
      2: v = ALL_ONE;
      3: v = 64'($signed($urandom_range(0, 20)) - 10);
      4: v = {{32{v[31]}}, v[31:0]};
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_item(logic [4:0] mode, logic [63:0] a, logic [63:0] b);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    results_due.push_back(alu_result(mode, a, b));
  endtask

  task automatic idle_sender();
    int unsigned gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 1) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Directed rows; a known result is checked in place of the computed one.
  initial begin
    row_t dir[$];
    logic [63:0] a, b;
    logic [4:0]  m;
    int          n;
    dir = '{
      '{OP_ADD,  MAX_VAL, 64'd1,   1'b1, MIN_VAL},
      '{OP_SUB,  MIN_VAL, 64'd1,   1'b1, MAX_VAL},
      '{OP_MUL,  MAX_VAL, ALL_ONE, 1'b1, MIN_VAL + 1},
      '{OP_DIV,  64'd7,   64'd0,   1'b1, 64'd0},
      '{OP_MOD,  64'd7,   64'd0,   1'b1, 64'd0},
      '{OP_DIV,  MIN_VAL, ALL_ONE, 1'b1, MIN_VAL},
      '{OP_MOD,  MIN_VAL, ALL_ONE, 1'b1, 64'd0},
      '{OP_DIV,  -64'd7,  64'd2,   1'b1, -64'd3},
      '{OP_MOD,  -64'd7,  64'd2,   1'b1, -64'd1},
      '{OP_MOD,  64'd7,   -64'd2,  1'b1, 64'd1},
      '{OP_OR,   MIN_VAL, 64'd1,   1'b1, MIN_VAL + 1},
      '{OP_XOR,  ALL_ONE, MAX_VAL, 1'b1, MIN_VAL},
      '{OP_AND,  ALL_ONE, MAX_VAL, 1'b1, MAX_VAL},
      '{OP_SHL,  64'd1,   64'd127, 1'b1, MIN_VAL},
      '{OP_SHR,  MIN_VAL, 64'd63,  1'b1, ALL_ONE},
      '{OP_SHR,  MIN_VAL, 64'd64,  1'b1, MIN_VAL},
      '{OP_EQ,   MIN_VAL, MIN_VAL, 1'b1, 64'd1},
      '{OP_NE,   MIN_VAL, MIN_VAL, 1'b1, 64'd0},
      '{OP_LT,   MIN_VAL, MAX_VAL, 1'b1, 64'd1},
      '{OP_LE,   MAX_VAL, MIN_VAL, 1'b1, 64'd0},
      '{OP_GT,   64'd0,   ALL_ONE, 1'b1, 64'd1},
      '{OP_GE,   ALL_ONE, ALL_ONE, 1'b1, 64'd1},
      '{OP_LAND, MIN_VAL, 64'd0,   1'b1, 64'd0},
      '{OP_LOR,  64'd0,   MIN_VAL, 1'b1, 64'd1},
      '{OP_NEG,  MIN_VAL, ALL_ONE, 1'b1, MIN_VAL},
      '{OP_LNOT, 64'd0,   ALL_ONE, 1'b1, 64'd1},
      '{OP_NOT,  64'd0,   MAX_VAL, 1'b1, ALL_ONE},
      '{UNUSED_OP, ALL_ONE, ALL_ONE, 1'b1, 64'd0}
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir[i]) begin
      if (dir[i].known && alu_result(dir[i].mode, dir[i].a, dir[i].b) !== dir[i].res) begin
        mismatches++;
        if (mismatches <= 10) $display("Predictor disagrees on directed row %0d", i);
      end
      send_item(dir[i].mode, dir[i].a, dir[i].b);
      if (dir[i].known) results_due[$] = dir[i].res;
      idle_sender();
    end
    for (n = 0; n < 1000; n++) begin
      m = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(21, 31))
                                       : 5'($urandom_range(0, 20));
      a = rand_operand();
      b = rand_operand();
      if ((m == OP_SHL || m == OP_SHR) && $urandom_range(0, 1)) b[5:0] = 6'($urandom);
      if (n == 300) long_hold = 1'b1;
      // One pause until the pipeline has drained completely.
      if (n == 600) begin
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk_i);
      end
      send_item(m, a, b);
      if (n < 300 || n > 400) idle_sender();
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off while the sender keeps pushing.
  initial begin
    int unsigned gap;
    wait (rst_ni);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 1) == 0) gap = 0;
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    logic [63:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result %h arrived with none outstanding", m_axis_tdata);
      end else begin
        want = results_due.pop_front();
        if (m_axis_tdata !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: expected %h, got %h", want, m_axis_tdata);
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
